/* rtl/vlsd_pkg.sv */
// vector list segment decoder: shared types and operation codes
// no dependencies; imported by the front end, queue, back end and top level
package vlsd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned OP_W    = 2;

  // work items handed from the front end to the back end
  localparam logic [OP_W-1:0] OP_Y      = 2'd0;
  localparam logic [OP_W-1:0] OP_XFIRST = 2'd1;
  localparam logic [OP_W-1:0] OP_XSEG   = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic [BYTE_W-1:0] x_scale;
    logic [BYTE_W-1:0] y_scale;
    logic [BYTE_W-1:0] center_x;
    logic [BYTE_W-1:0] center_y;
    logic [BYTE_W-1:0] fade_level;
  } cfg_t;

endpackage

/* rtl/vlsd_front.sv */
// front end: accepts list bytes, tracks y/x pairing and list end, queues work
// depends on vlsd_pkg
module vlsd_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_list_byte,
  input  logic                   in_list_start,
  input  logic                   q_full,
  output logic                   q_push,
  output vlsd_pkg::entry_t       q_entry
);
  import vlsd_pkg::*;

  localparam logic [BYTE_W-1:0] END_MARK_MIN = 8'hFA;

  logic awaiting_x_r, awaiting_x_nxt;
  logic pen_set_r, pen_set_nxt;
  logic ended_r, ended_nxt;
  logic beat;
  logic aw_eff, pen_eff, ended_eff;

  assign in_ready = !q_full;
  assign beat     = in_valid && in_ready;

  // a list start clears the pairing state before the byte is classified
  assign aw_eff    = awaiting_x_r && !in_list_start;
  assign pen_eff   = pen_set_r && !in_list_start;
  assign ended_eff = ended_r && !in_list_start;

  always_comb begin
    awaiting_x_nxt = awaiting_x_r;
    pen_set_nxt    = pen_set_r;
    ended_nxt      = ended_r;
    q_push         = 1'b0;
    q_entry.op     = OP_Y;
    q_entry.data   = in_list_byte;
    if (beat) begin
      awaiting_x_nxt = aw_eff;
      pen_set_nxt    = pen_eff;
      ended_nxt      = ended_eff;
      if (!ended_eff) begin
        if (!aw_eff) begin
          if (in_list_byte >= END_MARK_MIN) begin
            ended_nxt = 1'b1;
          end else begin
            q_push         = 1'b1;
            awaiting_x_nxt = 1'b1;
          end
        end else begin
          q_push         = 1'b1;
          q_entry.op     = pen_eff ? OP_XSEG : OP_XFIRST;
          awaiting_x_nxt = 1'b0;
          pen_set_nxt    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_x_r <= 1'b0;
      pen_set_r    <= 1'b0;
      ended_r      <= 1'b0;
    end else begin
      awaiting_x_r <= awaiting_x_nxt;
      pen_set_r    <= pen_set_nxt;
      ended_r      <= ended_nxt;
    end
  end

`ifndef SYNTHESIS
  a_ended_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r && !in_list_start |-> !q_push)
    else $error("work queued after end of list");
  a_segment_needs_pen: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && q_entry.op == OP_XSEG |-> pen_set_r && awaiting_x_r)
    else $error("segment queued without start point");
  a_start_first_is_y: assert property (@(posedge clk) disable iff (!rst_n)
    beat && in_list_start && q_push |-> q_entry.op == OP_Y)
    else $error("first byte of a list not taken as y");
`endif

endmodule

/* rtl/vlsd_fifo.sv */
// short work queue between the front and back ends
// depends on vlsd_pkg
module vlsd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  vlsd_pkg::entry_t push_entry,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output vlsd_pkg::entry_t pop_entry
);
  import vlsd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  entry_t           slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full      = (count_r == FULL_CNT);
  assign not_empty = (count_r != '0);
  assign pop_entry = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a push");
`endif

endmodule

/* rtl/vlsd_back.sv */
// back end: scales coordinates about the centroid, keeps the pen, emits segments
// depends on vlsd_pkg
module vlsd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vlsd_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  input  vlsd_pkg::entry_t     q_entry,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [9:0]    out_seg_x_start,
  output logic signed [9:0]    out_seg_y_start,
  output logic signed [9:0]    out_seg_x_end,
  output logic signed [9:0]    out_seg_y_end
);
  import vlsd_pkg::*;

  localparam int unsigned SHIFT_BITS = 7;
  localparam int unsigned PROD_W     = 2 * BYTE_W;
  localparam int unsigned Q_W        = PROD_W - SHIFT_BITS;
  localparam logic [PROD_W-1:0] ROUND_ADD = PROD_W'((1 << SHIFT_BITS) - 1);
  localparam logic [BYTE_W-1:0] FADE_OFF  = 8'hFF;

  logic [BYTE_W-1:0]  scale, center, delta, mag;
  logic               neg;
  logic [PROD_W-1:0]  prod, prod_adj;
  logic [Q_W-1:0]     q;
  logic [COORD_W-1:0] coord;
  logic               is_y, emit;

  logic [COORD_W-1:0] held_y_r, pen_x_r, pen_y_r;
  logic               out_valid_r;
  logic [COORD_W-1:0] xs_r, ys_r, xe_r, ye_r;

  assign is_y   = (q_entry.op == OP_Y);
  assign scale  = is_y ? cfg.y_scale : cfg.x_scale;
  assign center = is_y ? cfg.center_y : cfg.center_x;

  // signed byte delta, magnitude scaled, floor shift on the signed product
  assign delta    = q_entry.data - center;
  assign neg      = delta[BYTE_W-1];
  assign mag      = neg ? (~delta + 1'b1) : delta;
  assign prod     = PROD_W'(mag) * PROD_W'(scale);
  assign prod_adj = neg ? prod + ROUND_ADD : prod;
  assign q        = prod_adj[PROD_W-1:SHIFT_BITS];
  assign coord    = neg ? COORD_W'(center) - COORD_W'(q)
                        : COORD_W'(center) + COORD_W'(q);

  assign emit  = (q_entry.op == OP_XSEG) && (cfg.fade_level != FADE_OFF);
  assign q_pop = q_valid && (!emit || !out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      unique case (q_entry.op)
        OP_Y: begin
          held_y_r <= coord;
        end
        OP_XFIRST, OP_XSEG: begin
          pen_x_r <= coord;
          pen_y_r <= held_y_r;
          if (emit) begin
            xs_r <= pen_x_r;
            ys_r <= pen_y_r;
            xe_r <= coord;
            ye_r <= held_y_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_seg_x_start = xs_r;
  assign out_seg_y_start = ys_r;
  assign out_seg_x_end   = xe_r;
  assign out_seg_y_end   = ye_r;

`ifndef SYNTHESIS
  a_only_segments_emit: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && q_entry.op != OP_XSEG |=> !$rose(out_valid_r))
    else $error("result raised by a non-segment item");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(q_pop && emit))
    else $error("pending result overwritten");
  a_fade_silent: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.fade_level == FADE_OFF && !out_valid_r |=> !out_valid_r)
    else $error("segment emitted while faded out");
`endif

endmodule

/* rtl/vector_list_segment_decoder.sv */
// vector list segment decoder, top level: config registers, front end, queue, back end
// depends on vlsd_pkg, vlsd_front, vlsd_fifo, vlsd_back
// throughput: one list byte per cycle while the queue is not full, set by the single 8x8 scaling multiplier
// output path: the x byte is queued, and its segment is registered on the output when the back end pops it
// reset: synchronous active low; clears pairing state, queue and output valid,
// and loads the register defaults (scales 128, centroid 128/96, fade 0)
module vector_list_segment_decoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_list_byte,
  input  logic              in_list_start,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [9:0] out_seg_x_start,
  output logic signed [9:0] out_seg_y_start,
  output logic signed [9:0] out_seg_x_end,
  output logic signed [9:0] out_seg_y_end
);
  import vlsd_pkg::*;

  localparam logic [2:0] REG_X_SCALE    = 3'd0;
  localparam logic [2:0] REG_Y_SCALE    = 3'd1;
  localparam logic [2:0] REG_CENTER_X   = 3'd2;
  localparam logic [2:0] REG_CENTER_Y   = 3'd3;
  localparam logic [2:0] REG_FADE_LEVEL = 3'd4;

  cfg_t   cfg_r;
  logic   q_push, q_full, q_pop, q_not_empty;
  entry_t push_entry, pop_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.x_scale    <= 8'd128;
      cfg_r.y_scale    <= 8'd128;
      cfg_r.center_x   <= 8'd128;
      cfg_r.center_y   <= 8'd96;
      cfg_r.fade_level <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_SCALE:    cfg_r.x_scale    <= cfg_wdata;
        REG_Y_SCALE:    cfg_r.y_scale    <= cfg_wdata;
        REG_CENTER_X:   cfg_r.center_x   <= cfg_wdata;
        REG_CENTER_Y:   cfg_r.center_y   <= cfg_wdata;
        REG_FADE_LEVEL: cfg_r.fade_level <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  vlsd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_list_byte  (in_list_byte),
    .in_list_start (in_list_start),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  vlsd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .pop_entry  (pop_entry)
  );

  vlsd_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_not_empty),
    .q_entry         (pop_entry),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_seg_x_start (out_seg_x_start),
    .out_seg_y_start (out_seg_y_start),
    .out_seg_x_end   (out_seg_x_end),
    .out_seg_y_end   (out_seg_y_end)
  );

endmodule

/* bench/vlsd_seg_checker.sv */
// segment checker for the vector list segment decoder: register index names,
// a predictor of the decoded segments and the comparison against the result channel
// depends on vlsd_pkg for the coordinate width
package vlsd_tb_pkg;

  typedef enum logic [2:0] {
    REG_X_SCALE    = 3'd0,
    REG_Y_SCALE    = 3'd1,
    REG_CENTER_X   = 3'd2,
    REG_CENTER_Y   = 3'd3,
    REG_FADE_LEVEL = 3'd4
  } cfg_reg_e;

  localparam logic [7:0] END_MARK_MIN = 8'hFA;
  localparam logic [7:0] FADE_BLANK   = 8'hFF;

endpackage

module vlsd_seg_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_index,
  input  logic [7:0]                          cfg_wdata,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [7:0]                          in_list_byte,
  input  logic                                in_list_start,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [vlsd_pkg::COORD_W-1:0] out_seg_x_start,
  input  logic signed [vlsd_pkg::COORD_W-1:0] out_seg_y_start,
  input  logic signed [vlsd_pkg::COORD_W-1:0] out_seg_x_end,
  input  logic signed [vlsd_pkg::COORD_W-1:0] out_seg_y_end,
  output int                                  fail_count,
  output int                                  outstanding
);
  import vlsd_pkg::*;
  import vlsd_tb_pkg::*;

  localparam int SCALE_SHIFT = 7;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } segment_t;

  // newest at the front, oldest taken from the back
  segment_t   expected_segs[$];

  logic [7:0] x_scale, y_scale, center_x, center_y, fade_level;
  logic       pairing_x, pen_valid, list_done;
  coord_t     held_y, pen_x, pen_y;

  // signed delta about the centre, scaled as signed, floor shift, centre added back
  function automatic coord_t rescale_byte(logic [7:0] b, logic [7:0] scale, logic [7:0] ctr);
    logic [7:0] d;
    int         delta;
    d     = b - ctr;
    delta = d[7] ? int'(d) - 256 : int'(d);
    return coord_t'(int'(ctr) + ((delta * int'(scale)) >>> SCALE_SHIFT));
  endfunction

  task automatic decode_list_byte(input logic [7:0] b, input logic first);
    coord_t   x;
    segment_t seg;
    if (first) begin
      pairing_x = 1'b0;
      pen_valid = 1'b0;
      list_done = 1'b0;
    end
    if (list_done) return;
    if (!pairing_x) begin
      if (b >= END_MARK_MIN) begin
        list_done = 1'b1;
      end else begin
        held_y    = rescale_byte(b, y_scale, center_y);
        pairing_x = 1'b1;
      end
      return;
    end
    x         = rescale_byte(b, x_scale, center_x);
    pairing_x = 1'b0;
    if (pen_valid && fade_level != FADE_BLANK) begin
      seg.x_start = pen_x;
      seg.y_start = pen_y;
      seg.x_end   = x;
      seg.y_end   = held_y;
      expected_segs.push_front(seg);
    end
    pen_x     = x;
    pen_y     = held_y;
    pen_valid = 1'b1;
  endtask

  task automatic check_segment();
    segment_t want;
    if (expected_segs.size() == 0) begin
      $error("segment beat with nothing expected: (%0d,%0d)-(%0d,%0d)",
             out_seg_x_start, out_seg_y_start, out_seg_x_end, out_seg_y_end);
      fail_count++;
      return;
    end
    want = expected_segs.pop_back();
    if (out_seg_x_start !== want.x_start) begin
      $error("seg_x_start: expected %0d, got %0d", want.x_start, out_seg_x_start);
      fail_count++;
    end
    if (out_seg_y_start !== want.y_start) begin
      $error("seg_y_start: expected %0d, got %0d", want.y_start, out_seg_y_start);
      fail_count++;
    end
    if (out_seg_x_end !== want.x_end) begin
      $error("seg_x_end: expected %0d, got %0d", want.x_end, out_seg_x_end);
      fail_count++;
    end
    if (out_seg_y_end !== want.y_end) begin
      $error("seg_y_end: expected %0d, got %0d", want.y_end, out_seg_y_end);
      fail_count++;
    end
  endtask

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      x_scale    = 8'd128;
      y_scale    = 8'd128;
      center_x   = 8'd128;
      center_y   = 8'd96;
      fade_level = 8'd0;
      pairing_x  = 1'b0;
      pen_valid  = 1'b0;
      list_done  = 1'b0;
      held_y     = '0;
      pen_x      = '0;
      pen_y      = '0;
      expected_segs.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_X_SCALE:    x_scale    = cfg_wdata;
          REG_Y_SCALE:    y_scale    = cfg_wdata;
          REG_CENTER_X:   center_x   = cfg_wdata;
          REG_CENTER_Y:   center_y   = cfg_wdata;
          REG_FADE_LEVEL: fade_level = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) check_segment();
      if (in_valid && in_ready) decode_list_byte(in_list_byte, in_list_start);
    end
    outstanding = expected_segs.size();
  end

endmodule

/* bench/vector_list_segment_decoder_tb.sv */
// testbench top for the vector list segment decoder: clock, reset, list byte
// stimulus, register settings per phase and the verdict
// depends on vlsd_pkg, vlsd_tb_pkg, vlsd_seg_checker and the decoder itself
module vector_list_segment_decoder_tb;

  import vlsd_pkg::*;
  import vlsd_tb_pkg::*;

  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 90;

  logic                      clk           = 1'b0;
  logic                      rst_n         = 1'b0;
  logic                      cfg_we        = 1'b0;
  logic [2:0]                cfg_index     = '0;
  logic [7:0]                cfg_wdata     = '0;
  logic                      in_valid      = 1'b0;
  logic                      in_ready;
  logic [7:0]                in_list_byte  = '0;
  logic                      in_list_start = 1'b0;
  logic                      out_valid;
  logic                      out_ready     = 1'b0;
  logic signed [COORD_W-1:0] out_seg_x_start, out_seg_y_start;
  logic signed [COORD_W-1:0] out_seg_x_end, out_seg_y_end;
  int                        fail_count, outstanding;
  bit                        calm          = 1'b0;
  int                        items_sent    = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  vector_list_segment_decoder DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_list_byte    (in_list_byte),
    .in_list_start   (in_list_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_seg_x_start (out_seg_x_start),
    .out_seg_y_start (out_seg_y_start),
    .out_seg_x_end   (out_seg_x_end),
    .out_seg_y_end   (out_seg_y_end)
  );

  vlsd_seg_checker seg_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_list_byte    (in_list_byte),
    .in_list_start   (in_list_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_seg_x_start (out_seg_x_start),
    .out_seg_y_start (out_seg_y_start),
    .out_seg_x_end   (out_seg_x_end),
    .out_seg_y_end   (out_seg_y_end),
    .fail_count      (fail_count),
    .outstanding     (outstanding)
  );

  // called at a falling edge, returns at the falling edge after the beat
  task automatic push_byte(input logic [7:0] b, input logic first, input bit live);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid      = 1'b1;
    in_list_byte  = b;
    in_list_start = first;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (live) items_sent++;
  endtask

  task automatic push_point(input logic [7:0] y, input logic [7:0] x, input logic first);
    push_byte(y, first, 1'b1);
    push_byte(x, 1'b0, 1'b1);
  endtask

  // hold off until every segment is out, then let the queue behind the front end empty
  task automatic wait_idle();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_e r, input logic [7:0] v);
    cfg_we    = 1'b1;
    cfg_index = r;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic apply_settings(input int phase);
    logic [7:0] xs, ys, cx, cy, fade;
    xs   = 8'($urandom_range(0, 255));
    ys   = 8'($urandom_range(0, 255));
    cx   = 8'($urandom_range(0, 255));
    cy   = 8'($urandom_range(0, 255));
    fade = ($urandom_range(0, 3) == 0) ? FADE_BLANK : 8'($urandom_range(0, 254));
    if (phase == 1) begin
      {xs, ys, cx, cy, fade} = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE};
    end else if (phase == 2) begin
      {xs, ys, cx, cy, fade} = {8'h00, 8'h00, 8'h00, 8'h00, FADE_BLANK};
    end else if (phase == PHASES - 1) begin
      fade = 8'($urandom_range(0, 254));
    end
    cfg_write(REG_X_SCALE, xs);
    cfg_write(REG_Y_SCALE, ys);
    cfg_write(REG_CENTER_X, cx);
    cfg_write(REG_CENTER_Y, cy);
    cfg_write(REG_FADE_LEVEL, fade);
  endtask

  task automatic send_list();
    int pairs;
    int tail;
    pairs = $urandom_range(1, 10);
    push_point(8'($urandom_range(0, END_MARK_MIN - 1)), 8'($urandom_range(0, 255)), 1'b1);
    for (int i = 1; i < pairs; i++) begin
      // now and then a new list cuts in on the y position
      if ($urandom_range(0, 29) == 0)
        push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
      push_point(8'($urandom_range(0, END_MARK_MIN - 1)), 8'($urandom_range(0, 255)), 1'b0);
    end
    tail = $urandom_range(0, 9);
    if (tail < 6) begin
      push_byte(8'($urandom_range(END_MARK_MIN, 255)), 1'b0, 1'b1);
      repeat ($urandom_range(0, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end else if (tail < 8) begin
      // lone y byte, dropped by the next list
      push_byte(8'($urandom_range(0, END_MARK_MIN - 1)), 1'b0, 1'b1);
    end else begin
      repeat (3) push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0), 1'b1);
    end
    if ($urandom_range(0, 14) == 0) wait_idle();
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // pen, full range coordinates, end byte and bytes it hides
    push_point(8'h00, 8'h00, 1'b1);
    push_point(8'hF9, 8'hFF, 1'b0);
    push_point(8'h80, 8'h7F, 1'b0);
    push_point(8'h7F, 8'hFA, 1'b0);
    push_byte(END_MARK_MIN, 1'b0, 1'b1);
    push_byte(8'h10, 1'b0, 1'b0);
    push_byte(8'h20, 1'b0, 1'b0);
    // dropped y byte, then a fresh list
    push_byte(8'h55, 1'b1, 1'b1);
    push_point(8'hAA, 8'h55, 1'b1);
    push_point(8'h33, 8'hCC, 1'b0);
    // list that ends at once
    push_byte(8'hFF, 1'b1, 1'b1);
    push_byte(8'h01, 1'b0, 1'b0);
    push_byte(8'hFE, 1'b1, 1'b1);
    push_point(8'h01, 8'h80, 1'b1);
    push_point(8'hFE, 8'h01, 1'b0);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        wait_idle();
        apply_settings(phase);
      end
      calm       = (phase == PHASES - 1);
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) send_list();
    end

    wait_idle();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
